@@ rtl/gri_pkg.sv @@
`default_nettype none
// ============================================================================
// gri_pkg
// Shared types and constants of the gravity-removed forward integrator.
// ============================================================================
package gri_pkg;

    localparam int unsigned N_AXES = 3;

    localparam logic [15:0] WEIGHT_RESET = 16'd64225;
    localparam logic signed [31:0] G_ONE_Q28 = 32'sd268435456;

    // Velocity step divides by 16000, position step by 1000 (both rounded).
    localparam logic [31:0] VEL_DIV = 32'd16000;
    localparam logic [31:0] POS_DIV = 32'd1000;
    localparam logic signed [57:0] VEL_BIAS = 58'sd8000;
    localparam logic signed [57:0] POS_BIAS = 58'sd500;

    // 16000 = 125 << 7 and 1000 = 125 << 3: shift first, then divide by 125
    // one byte a cycle with a reciprocal that is exact below 32000.
    localparam int unsigned VEL_SHIFT       = 7;
    localparam int unsigned POS_SHIFT       = 3;
    localparam logic [6:0]  DIV_ODD         = 7'd125;
    localparam logic [15:0] DIV_RECIP       = 16'd33555;
    localparam int unsigned DIV_RECIP_SHIFT = 22;
    localparam int unsigned DIV_DIGITS      = 7;

    localparam logic signed [63:0] VEL_MAX = 64'sd549755813887;
    localparam logic signed [63:0] VEL_MIN = -64'sd549755813888;
    localparam logic signed [63:0] POS_MAX = 64'sd36028797018963967;
    localparam logic signed [63:0] POS_MIN = -64'sd36028797018963968;

    typedef struct packed {
        logic mul;   // register the two filter products
        logic upd;   // fold products into the gravity estimate
        logic sq;    // register the squared magnitude
    } t_lane_ctl;

endpackage
`default_nettype wire

@@ rtl/gri_if.sv @@
`default_nettype none
// ============================================================================
// gri_if
// Valid/ready channels for input samples and integrator results.
// ============================================================================
interface gri_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [15:0] elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, elapsed_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, elapsed_ms, output ready);
endinterface

interface gri_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] fwd_pos;
    logic signed [31:0] fwd_vel;
    logic               saturated;

    modport source (output valid, fwd_pos, fwd_vel, saturated,
                    input ready);
    modport sink   (input valid, fwd_pos, fwd_vel, saturated,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/gri_lane.sv @@
`default_nettype none
// ============================================================================
// gri_lane
// One axis: low-pass gravity estimate in Q4.28 and its squared magnitude.
// ============================================================================
module gri_lane
    import gri_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire logic        [15:0] i_weight,
    input  wire logic signed [15:0] i_sample,
    input  wire logic signed [31:0] i_g_init,
    output logic signed [31:0]      o_g,
    output logic        [63:0]      o_sq
);

    logic signed [31:0] r_g;
    logic signed [48:0] r_p1;
    logic signed [47:0] r_p2;
    logic        [63:0] r_sq;

    logic signed [16:0] w_w;
    logic        [16:0] w_iw;
    logic signed [17:0] w_iw_s;
    logic signed [29:0] w_a;
    logic signed [49:0] w_sum;
    logic        [31:0] w_mag;

    assign w_w    = signed'({1'b0, i_weight});
    assign w_iw   = 17'(18'd65536 - {2'b00, i_weight});
    assign w_iw_s = signed'({1'b0, w_iw});
    assign w_a    = signed'({i_sample, 14'b0});
    assign w_sum  = 50'(r_p1) + 50'(r_p2) + 50'sd32768;
    assign w_mag  = r_g[31] ? 32'(-r_g) : 32'(r_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= i_g_init;
        end else if (i_ctl.upd) begin
            r_g <= w_sum[47:16];
        end
        if (i_ctl.mul) begin
            r_p1 <= 49'(w_w) * 49'(r_g);
            r_p2 <= 48'(w_iw_s) * 48'(w_a);
        end
        if (i_ctl.sq) begin
            r_sq <= 64'(w_mag) * 64'(w_mag);
        end
    end

    assign o_g  = r_g;
    assign o_sq = r_sq;

endmodule
`default_nettype wire

@@ rtl/gri_isqrt.sv @@
`default_nettype none
// ============================================================================
// gri_isqrt
// Floor square root of a 64-bit value, one root bit per cycle.
// ============================================================================
module gri_isqrt
    import gri_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_rad,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [32:0] r_rem;
    logic [31:0] r_root;

    logic [34:0] w_rem_s;
    logic [34:0] w_trial;
    logic        w_take;

    assign w_rem_s = {r_rem, r_rad[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_take  = (w_rem_s >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_take ? 33'(w_rem_s - w_trial) : 33'(w_rem_s);
            r_root <= {r_root[30:0], w_take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

@@ rtl/gri_div.sv @@
`default_nettype none
// ============================================================================
// gri_div
// Restoring unsigned divider, 64-bit numerator, 32-bit divisor, bit a cycle.
// ============================================================================
module gri_div
    import gri_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_den;
    logic [32:0] r_rem;

    logic [32:0] w_t;
    logic        w_take;

    assign w_t    = {r_rem[31:0], r_q[63]};
    assign w_take = (w_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_take ? (w_t - {1'b0, r_den}) : w_t;
            r_q   <= {r_q[62:0], w_take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

@@ rtl/gravity_removed_forward_integrator.sv @@
`default_nettype none
// ============================================================================
// gravity_removed_forward_integrator
// Gravity-removed forward velocity and position from raw accelerometer beats.
// ============================================================================
// Steps: the result waits on the square root, the ratio divide (skipped when
//   the gravity magnitude is zero) and two divides by a constant.
// Flow: one beat at a time; a new input beat is taken once the previous
//   result sits in the output register, which stalls while full.
// Reset: synchronous, active low; gravity to (0, 0, 1 g), velocity and
//   position to zero, filter weight to 64225.
// ============================================================================
module gravity_removed_forward_integrator
    import gri_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    gri_in_if.sink           i_in,
    gri_out_if.source        o_out
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_GMUL, ST_GUPD, ST_GSQ, ST_SUM, ST_SQRT_GO, ST_SQRT,
        ST_RDIV_GO, ST_RDIV, ST_FMUL, ST_VDIV_GO, ST_VDIV, ST_VUPD,
        ST_PMUL, ST_PDIV_GO, ST_PDIV, ST_PUPD, ST_DONE
    } t_state;

    t_state r_state;

    logic        [15:0] r_weight;
    logic signed [15:0] r_smp [N_AXES];
    logic        [15:0] r_ms;
    logic        [63:0] r_sumsq;
    logic        [31:0] r_mag;
    logic signed [32:0] r_ratio;
    logic signed [57:0] r_prod;
    logic               r_neg;
    logic signed [39:0] r_vacc;
    logic signed [55:0] r_pacc;
    logic               r_sat;

    logic               r_out_valid;
    logic signed [47:0] r_out_pos;
    logic signed [31:0] r_out_vel;
    logic               r_out_sat;

    // Lanes: one per axis, all stepped together.
    t_lane_ctl          w_ctl;
    logic signed [31:0] w_g    [N_AXES];
    logic        [63:0] w_sq   [N_AXES];
    logic signed [31:0] w_ginit[N_AXES];

    assign w_ginit[0] = '0;
    assign w_ginit[1] = '0;
    assign w_ginit[2] = G_ONE_Q28;

    always_comb begin
        w_ctl.mul = (r_state == ST_GMUL);
        w_ctl.upd = (r_state == ST_GUPD);
        w_ctl.sq  = (r_state == ST_GSQ);
    end

    for (genvar gi = 0; gi < N_AXES; gi++) begin : g_lane
        gri_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_weight (r_weight),
            .i_sample (r_smp[gi]),
            .i_g_init (w_ginit[gi]),
            .o_g      (w_g[gi]),
            .o_sq     (w_sq[gi])
        );
    end

    // Magnitude of the gravity vector.
    logic        w_sqrt_busy;
    logic        w_sqrt_done;
    logic [31:0] w_root;

    gri_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SQRT_GO),
        .i_rad   (r_sumsq),
        .o_busy  (w_sqrt_busy),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Divider for the gravity ratio gx / |g|.
    logic        w_div_start;
    logic [63:0] w_div_num;
    logic [31:0] w_div_den;
    logic        w_div_busy;
    logic        w_div_done;
    logic [63:0] w_quo;

    logic        [31:0] w_gx_mag;
    logic               w_gx_neg;
    logic signed [57:0] w_u;
    logic signed [32:0] w_rq;
    logic signed [32:0] w_f;
    logic signed [63:0] w_q;
    logic signed [63:0] w_step;
    logic signed [63:0] w_vsum;
    logic signed [63:0] w_psum;

    // Divide by 125, one byte of the numerator a cycle, top byte first.
    logic        [55:0] r_cnum;
    logic        [6:0]  r_crem;
    logic        [2:0]  r_ccnt;
    logic        [14:0] w_ct;
    logic        [29:0] w_cprod;
    logic        [7:0]  w_cqd;
    logic        [14:0] w_cback;
    logic        [6:0]  w_crem;

    assign w_ct    = {r_crem, r_cnum[55:48]};
    assign w_cprod = 30'(w_ct) * 30'(DIV_RECIP);
    assign w_cqd   = 8'(w_cprod >> DIV_RECIP_SHIFT);
    assign w_cback = 15'(w_cqd) * 15'(DIV_ODD);
    assign w_crem  = 7'(w_ct - w_cback);

    assign w_gx_neg = w_g[0][31];
    assign w_gx_mag = w_gx_neg ? 32'(-w_g[0]) : 32'(w_g[0]);
    assign w_rq     = signed'({4'b0000, w_quo[28:0]});
    assign w_f      = 33'(signed'({r_smp[0], 14'b0})) + r_ratio;
    assign w_q      = signed'({8'b0, r_cnum});
    assign w_step   = r_neg ? -w_q : w_q;
    assign w_vsum   = 64'(r_vacc) + w_step;
    assign w_psum   = 64'(r_pacc) + w_step;

    // Floor division of a signed value: fold negatives to a biased magnitude.
    always_comb begin
        w_u = r_prod;
        if (r_prod[57]) begin
            w_u = (r_state == ST_VDIV_GO) ? (-r_prod + 58'(VEL_DIV) - 58'sd1)
                                          : (-r_prod + 58'(POS_DIV) - 58'sd1);
        end
    end

    assign w_div_start = (r_state == ST_RDIV_GO) && (r_mag != '0);
    assign w_div_num   = {4'b0000, w_gx_mag, 28'b0};
    assign w_div_den   = r_mag;

    gri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    // Sequencer, accumulators and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vacc      <= '0;
            r_pacc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the sink takes it, unless a new one lands
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_smp[0] <= i_in.accel_x;
                        r_smp[1] <= i_in.accel_y;
                        r_smp[2] <= i_in.accel_z;
                        r_ms     <= i_in.elapsed_ms;
                        r_state  <= ST_GMUL;
                    end
                end
                ST_GMUL:    r_state <= ST_GUPD;
                ST_GUPD:    r_state <= ST_GSQ;
                ST_GSQ:     r_state <= ST_SUM;
                ST_SUM: begin
                    r_sumsq <= w_sq[0] + w_sq[1] + w_sq[2];
                    r_state <= ST_SQRT_GO;
                end
                ST_SQRT_GO: r_state <= ST_SQRT;
                ST_SQRT: begin
                    if (w_sqrt_done) begin
                        r_mag   <= w_root;
                        r_state <= ST_RDIV_GO;
                    end
                end
                ST_RDIV_GO: begin
                    // zero magnitude: no ratio term
                    if (r_mag == '0) begin
                        r_ratio <= '0;
                        r_state <= ST_FMUL;
                    end else begin
                        r_state <= ST_RDIV;
                    end
                end
                ST_RDIV: begin
                    if (w_div_done) begin
                        r_ratio <= w_gx_neg ? -w_rq : w_rq;
                        r_state <= ST_FMUL;
                    end
                end
                ST_FMUL: begin
                    r_prod  <= 58'(w_f) * 58'(signed'({1'b0, r_ms})) + VEL_BIAS;
                    r_state <= ST_VDIV_GO;
                end
                ST_VDIV_GO: begin
                    r_neg   <= r_prod[57];
                    r_cnum  <= 56'(unsigned'(w_u) >> VEL_SHIFT);
                    r_crem  <= '0;
                    r_ccnt  <= '0;
                    r_state <= ST_VDIV;
                end
                ST_VDIV: begin
                    r_cnum <= {r_cnum[47:0], w_cqd};
                    r_crem <= w_crem;
                    r_ccnt <= r_ccnt + 3'd1;
                    if (r_ccnt == 3'(DIV_DIGITS - 1)) begin
                        r_state <= ST_VUPD;
                    end
                end
                ST_VUPD: begin
                    // clamp velocity to its 40-bit range
                    if (w_vsum > VEL_MAX) begin
                        r_vacc <= VEL_MAX[39:0];
                        r_sat  <= 1'b1;
                    end else if (w_vsum < VEL_MIN) begin
                        r_vacc <= VEL_MIN[39:0];
                        r_sat  <= 1'b1;
                    end else begin
                        r_vacc <= w_vsum[39:0];
                        r_sat  <= 1'b0;
                    end
                    r_state <= ST_PMUL;
                end
                ST_PMUL: begin
                    r_prod  <= 58'(r_vacc) * 58'(signed'({1'b0, r_ms})) + POS_BIAS;
                    r_state <= ST_PDIV_GO;
                end
                ST_PDIV_GO: begin
                    r_neg   <= r_prod[57];
                    r_cnum  <= 56'(unsigned'(w_u) >> POS_SHIFT);
                    r_crem  <= '0;
                    r_ccnt  <= '0;
                    r_state <= ST_PDIV;
                end
                ST_PDIV: begin
                    r_cnum <= {r_cnum[47:0], w_cqd};
                    r_crem <= w_crem;
                    r_ccnt <= r_ccnt + 3'd1;
                    if (r_ccnt == 3'(DIV_DIGITS - 1)) begin
                        r_state <= ST_PUPD;
                    end
                end
                ST_PUPD: begin
                    // clamp position to its 56-bit range
                    if (w_psum > POS_MAX) begin
                        r_pacc <= POS_MAX[55:0];
                        r_sat  <= 1'b1;
                    end else if (w_psum < POS_MIN) begin
                        r_pacc <= POS_MIN[55:0];
                        r_sat  <= 1'b1;
                    end else begin
                        r_pacc <= w_psum[55:0];
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= r_pacc[55:8];
                        r_out_vel   <= r_vacc[39:8];
                        r_out_sat   <= r_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.fwd_pos    = r_out_pos;
    assign o_out.fwd_vel    = r_out_vel;
    assign o_out.saturated  = r_out_sat;

`ifndef SYNTHESIS
    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_div_busy && !w_sqrt_busy))
        else $error("iterative unit busy while idle");

    a_zero_mag_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDIV_GO && r_mag == '0) |=> (r_ratio == '0))
        else $error("ratio not cleared for zero gravity magnitude");

    a_single_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_busy && w_sqrt_busy))
        else $error("divider and square root overlap");
`endif

endmodule
`default_nettype wire
